// File: src/bfet_pkg.sv
// Shared types and codes for the best-fit free extent table.
package bfet_pkg;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_FIND = 2'd1;
    localparam logic [1:0] MODE_DEL  = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_MISS = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] group;
        logic [31:0] payload;
        logic [23:0] length;
        logic [23:0] max_length;
    } rec_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] extent_offset;
        logic [31:0] group_offset;
        logic [31:0] payload_offset;
        logic [23:0] length;
        logic [23:0] max_length;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] hit_offset;
        logic [31:0] hit_group;
        logic [31:0] hit_payload;
        logic [23:0] hit_length;
        logic [23:0] hit_max_length;
        logic [6:0]  entry_count;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } rsp_t;

    typedef struct packed {
        logic        write;
        logic        shift;
        logic        exact;
        logic [31:0] req_offset;
        logic [23:0] req_length;
    } cell_ctl_t;

    typedef struct packed {
        logic found;
        rec_t rec;
    } cand_t;

endpackage

// File: src/bfet_cell.sv
// One slot of the table with its stage of the search chain.
module bfet_cell #(
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bfet_pkg::cell_ctl_t ctl,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [IDX_W-1:0]   del_idx,
    input  logic [CNT_W-1:0]   used,
    input  bfet_pkg::rec_t     wr_rec,
    input  bfet_pkg::rec_t     nbr_rec,
    input  logic               tok_in,
    input  bfet_pkg::cand_t    cand_in,
    input  logic [IDX_W-1:0]   cand_idx_in,
    output bfet_pkg::rec_t     rec,
    output logic               tok_out,
    output bfet_pkg::cand_t    cand_out,
    output logic [IDX_W-1:0]   cand_idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

    bfet_pkg::rec_t  rec_reg;
    logic            tok_reg;
    bfet_pkg::cand_t cand_reg;
    logic [IDX_W-1:0] cidx_reg;
    logic            occupied;
    logic            pick;

    assign occupied = MY_CNT < used;

    // A later cell takes over on ties, so the newest equal entry wins.
    always_comb
    begin
        pick = 1'b0;
        if (occupied)
        begin
            if (ctl.exact)
                pick = (rec_reg.length == ctl.req_length) &&
                       (rec_reg.offset == ctl.req_offset);
            else
                pick = (rec_reg.length >= ctl.req_length) &&
                       (!cand_in.found || rec_reg.length <= cand_in.rec.length);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= 1'b0;
        else
            tok_reg <= tok_in;
    end

    always_ff @(posedge clk)
    begin
        if (pick)
        begin
            cand_reg <= {1'b1, rec_reg};
            cidx_reg <= MY_IDX;
        end
        else
        begin
            cand_reg <= cand_in;
            cidx_reg <= cand_idx_in;
        end
        if (ctl.write && wr_idx == MY_IDX)
            rec_reg <= wr_rec;
        else if (ctl.shift && MY_IDX >= del_idx)
            rec_reg <= nbr_rec;
    end

    assign rec          = rec_reg;
    assign tok_out      = tok_reg;
    assign cand_out     = cand_reg;
    assign cand_idx_out = cidx_reg;

endmodule

// File: src/best_fit_free_extent_table_core.sv
// An add goes from the idle state to the finish state, which registers the result beat.
// A find or delete first sweeps a token down the cell chain, then registers its result.
// Requests are taken one at a time; the chain length sets the search time.
// A new beat is taken while the previous result still waits in the output register.
// Reset clears the entry count, the hit and miss counters and all control state.
module best_fit_free_extent_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bfet_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output bfet_pkg::rsp_t rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    bfet_pkg::state_t    state_reg, state_next;
    bfet_pkg::req_t      req_reg;
    logic                launch_reg;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [31:0]         hit_reg, hit_next;
    logic [31:0]         miss_reg, miss_next;
    logic                found_reg;
    bfet_pkg::rec_t      res_rec_reg;
    logic [IDX_W-1:0]    res_idx_reg;
    bfet_pkg::rsp_t      rsp_reg, rsp_next;
    logic                rsp_valid_reg;

    logic                accept, fire, full, is_search, launch;
    bfet_pkg::cell_ctl_t ctl;
    bfet_pkg::rec_t      wr_rec;

    logic               tok  [0:TABLE_DEPTH];
    bfet_pkg::cand_t    cand [0:TABLE_DEPTH];
    logic [IDX_W-1:0]   cidx [0:TABLE_DEPTH];
    bfet_pkg::rec_t     recs [0:TABLE_DEPTH];

    assign accept    = req_valid && req_ready;
    assign full      = used_reg == FULL_CNT;
    assign is_search = req_reg.mode == bfet_pkg::MODE_FIND ||
                       req_reg.mode == bfet_pkg::MODE_DEL;
    assign launch    = accept && (req.mode == bfet_pkg::MODE_FIND ||
                                  req.mode == bfet_pkg::MODE_DEL);

    assign wr_rec = '{offset: req_reg.extent_offset, group: req_reg.group_offset,
                      payload: req_reg.payload_offset, length: req_reg.length,
                      max_length: req_reg.max_length};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bfet_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        fire       = 1'b0;
        case (state_reg)
            bfet_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                    state_next = launch ? bfet_pkg::S_SWEEP : bfet_pkg::S_FINISH;
            end
            bfet_pkg::S_SWEEP:
            begin
                if (tok[TABLE_DEPTH])
                    state_next = bfet_pkg::S_FINISH;
            end
            bfet_pkg::S_FINISH:
            begin
                fire = !rsp_valid_reg || rsp_ready;
                if (fire)
                    state_next = bfet_pkg::S_IDLE;
            end
            default:
                state_next = bfet_pkg::S_IDLE;
        endcase
    end

    // Commit of the operation: table update, counters and the result beat.
    always_comb
    begin
        ctl.write      = fire && req_reg.mode == bfet_pkg::MODE_ADD && !full;
        ctl.shift      = fire && req_reg.mode == bfet_pkg::MODE_DEL && found_reg;
        ctl.exact      = req_reg.mode == bfet_pkg::MODE_DEL && req_reg.extent_offset != 32'd0;
        ctl.req_offset = req_reg.extent_offset;
        ctl.req_length = req_reg.length;

        used_next = used_reg;
        hit_next  = hit_reg;
        miss_next = miss_reg;
        rsp_next  = '0;
        rsp_next.status = bfet_pkg::STATUS_MISS;
        if (req_reg.mode == bfet_pkg::MODE_ADD)
        begin
            if (full)
                rsp_next.status = bfet_pkg::STATUS_FULL;
            else
            begin
                rsp_next.status = bfet_pkg::STATUS_OK;
                used_next = used_reg + CNT_W'(1);
            end
        end
        else if (is_search)
        begin
            if (found_reg)
            begin
                rsp_next.status         = bfet_pkg::STATUS_OK;
                rsp_next.hit_offset     = res_rec_reg.offset;
                rsp_next.hit_group      = res_rec_reg.group;
                rsp_next.hit_payload    = res_rec_reg.payload;
                rsp_next.hit_length     = res_rec_reg.length;
                rsp_next.hit_max_length = res_rec_reg.max_length;
                hit_next = hit_reg + 32'd1;
                if (req_reg.mode == bfet_pkg::MODE_DEL)
                    used_next = used_reg - CNT_W'(1);
            end
            else
                miss_next = miss_reg + 32'd1;
        end
        rsp_next.entry_count = 7'(used_next);
        rsp_next.hit_total   = hit_next;
        rsp_next.miss_total  = miss_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg    <= 1'b0;
            used_reg      <= '0;
            hit_reg       <= '0;
            miss_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= launch;
            if (fire)
            begin
                used_reg      <= used_next;
                hit_reg       <= hit_next;
                miss_reg      <= miss_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req;
            found_reg <= 1'b0;
        end
        if (state_reg == bfet_pkg::S_SWEEP && tok[TABLE_DEPTH])
        begin
            found_reg   <= cand[TABLE_DEPTH].found;
            res_rec_reg <= cand[TABLE_DEPTH].rec;
            res_idx_reg <= cidx[TABLE_DEPTH];
        end
        if (fire)
            rsp_reg <= rsp_next;
    end

    assign tok[0]  = launch_reg;
    assign cand[0] = '0;
    assign cidx[0] = '0;
    // The top cell shifts in its own contents; it falls out of use anyway.
    assign recs[TABLE_DEPTH] = recs[TABLE_DEPTH-1];

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [IDX_W-1:0] wr_idx;
        assign wr_idx = used_reg[IDX_W-1:0];
        bfet_cell #(
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .wr_idx       (wr_idx),
            .del_idx      (res_idx_reg),
            .used         (used_reg),
            .wr_rec       (wr_rec),
            .nbr_rec      (recs[i+1]),
            .tok_in       (tok[i]),
            .cand_in      (cand[i]),
            .cand_idx_in  (cidx[i]),
            .rec          (recs[i]),
            .tok_out      (tok[i+1]),
            .cand_out     (cand[i+1]),
            .cand_idx_out (cidx[i+1])
        );
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: src/bfet_checker.sv
// Port-level checks for the best-fit free extent table, bound to the top level.
module bfet_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input bfet_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input bfet_pkg::rsp_t rsp
);

    localparam logic [6:0] FULL_CNT = 7'(TABLE_DEPTH);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat dropped or changed while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == bfet_pkg::STATUS_FULL |-> rsp.entry_count == FULL_CNT)
        else $error("table full reported below capacity");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != bfet_pkg::STATUS_OK |->
        rsp.hit_offset == 32'd0 && rsp.hit_length == 24'd0 && rsp.hit_group == 32'd0)
        else $error("record fields not zero on a failed operation");

    a_counters: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready ##1 rsp_valid && rsp.status == bfet_pkg::STATUS_FULL |->
        rsp.hit_total == $past(rsp.hit_total) || !$past(rsp_valid))
        else $error("hit count moved on a refused add");

endmodule

bind best_fit_free_extent_table_core bfet_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_bfet_checker (.*);

// File: test/bfet_checker.sv
// Checker for the best-fit free extent table: predicts every result beat and compares it.
`timescale 1ns / 100ps
module bfet_scoreboard #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  bfet_pkg::req_t   req,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  bfet_pkg::rsp_t   rsp,
    output int               error_count,
    output int               pending_count
);

    bfet_pkg::rec_t extents[$];
    logic [31:0]    hits;
    logic [31:0]    misses;
    bfet_pkg::rsp_t awaited[$];

    // Best fit: smallest length not below the request, the newest among equals.
    function automatic int best_fit(logic [23:0] want);
        int pick;
        pick = -1;
        for (int i = 0; i < extents.size(); i++)
            if (extents[i].length >= want &&
                (pick < 0 || extents[i].length <= extents[pick].length))
                pick = i;
        return pick;
    endfunction

    function automatic bfet_pkg::rsp_t table_update(bfet_pkg::req_t r);
        bfet_pkg::rsp_t o;
        int             k;
        o = '0;
        o.status = bfet_pkg::STATUS_MISS;
        if (r.mode == bfet_pkg::MODE_ADD) begin
            if (extents.size() >= TABLE_DEPTH)
                o.status = bfet_pkg::STATUS_FULL;
            else
            begin
                extents.push_back({r.extent_offset, r.group_offset, r.payload_offset,
                                   r.length, r.max_length});
                o.status = bfet_pkg::STATUS_OK;
            end
        end
        else if (r.mode == bfet_pkg::MODE_FIND || r.mode == bfet_pkg::MODE_DEL) begin
            if (r.mode == bfet_pkg::MODE_DEL && r.extent_offset != 0) begin
                k = -1;
                for (int i = 0; i < extents.size(); i++)
                    if (extents[i].length == r.length && extents[i].offset == r.extent_offset)
                        k = i;
            end
            else
                k = best_fit(r.length);
            if (k >= 0) begin
                o.status = bfet_pkg::STATUS_OK;
                {o.hit_offset, o.hit_group, o.hit_payload, o.hit_length,
                 o.hit_max_length} = extents[k];
                hits++;
                if (r.mode == bfet_pkg::MODE_DEL)
                    extents.delete(k);
            end
            else
                misses++;
        end
        o.entry_count = 7'(extents.size());
        o.hit_total   = hits;
        o.miss_total  = misses;
        return o;
    endfunction

    assign pending_count = awaited.size();

    always @(posedge clk or negedge rst_n)
    begin
        bfet_pkg::rsp_t e;
        if (!rst_n) begin
            extents.delete();
            awaited.delete();
            hits        = '0;
            misses      = '0;
            error_count = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready) begin
                if (awaited.size() == 0) begin
                    $display("%0t: result beat with none expected: %p", $time, rsp);
                    error_count++;
                end
                else
                begin
                    e = awaited.pop_front();
                    if (rsp !== e) begin
                        $display("%0t: mismatch: expected %p, actual %p", $time, e, rsp);
                        error_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                awaited.push_back(table_update(req));
        end
    end

endmodule

// File: test/tb_best_fit_free_extent_table_core.sv
// Testbench top for the best-fit free extent table: stimulus, reset and verdict.
`timescale 1ns / 100ps
module tb_best_fit_free_extent_table_core;

    localparam int DEPTH      = 64;
    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    bfet_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    bfet_pkg::rsp_t rsp;
    int   error_count;
    int   pending_count;
    int   send_idle_pct = 29;
    int   recv_idle_pct = 88;
    int   hold_off = 0;
    int   quiet_cycles = 0;
    logic [31:0] known_offsets[$];
    logic [23:0] known_lengths[$];

    always #1 clk = ~clk;

    best_fit_free_extent_table_core #(.TABLE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    bfet_scoreboard #(.TABLE_DEPTH(DEPTH)) u_scoreboard (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .error_count(error_count), .pending_count(pending_count)
    );

    // Receiver: random stalls, or a long counted hold-off when asked.
    always @(negedge clk)
    begin
        if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_best_fit_free_extent_table_core: FAIL");
            $finish;
        end
    end

    // Valid is dropped only when the sender idles, so it is written once per edge.
    task automatic send_beat(logic [1:0] op, logic [31:0] off, logic [23:0] len);
        bfet_pkg::req_t r;
        r.mode           = op;
        r.extent_offset  = off;
        r.group_offset   = $urandom;
        r.payload_offset = $urandom;
        r.length         = len;
        r.max_length     = 24'($urandom);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        if (op == bfet_pkg::MODE_ADD) begin
            known_offsets.push_back(off);
            known_lengths.push_back(len);
        end
    endtask

    // Short lengths collide often, so best fit and equal-length order get exercised.
    function automatic logic [23:0] rand_length();
        case ($urandom_range(3))
            0: return 24'($urandom_range(15));
            1: return 24'($urandom);
            default: return 24'($urandom_range(300));
        endcase
    endfunction

    task automatic random_beat();
        int          p;
        int          k;
        logic [31:0] off;
        p = $urandom_range(99);
        if (p < 45)
            send_beat(bfet_pkg::MODE_ADD, ($urandom_range(9) == 0) ? 32'd0 : $urandom,
                      rand_length());
        else if (p < 70)
            send_beat(bfet_pkg::MODE_FIND, 32'd0, rand_length());
        else if (p < 90 && known_offsets.size() > 0) begin
            // Delete by the offset and length of an earlier add; a zero offset makes it a best-fit delete.
            k   = $urandom_range(known_offsets.size() - 1);
            off = known_offsets[k];
            send_beat(bfet_pkg::MODE_DEL, off, known_lengths[k]);
        end
        else if (p < 96)
            send_beat(bfet_pkg::MODE_DEL, ($urandom_range(1) == 0) ? 32'd0 : $urandom,
                      rand_length());
        else
            send_beat(bfet_pkg::MODE_RSVD, $urandom, rand_length());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, extremes, equal lengths, wildcard delete, full table.
        send_beat(bfet_pkg::MODE_FIND, 32'd0, 24'd0);
        send_beat(bfet_pkg::MODE_DEL, 32'd0, 24'd0);
        send_beat(bfet_pkg::MODE_DEL, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_beat(bfet_pkg::MODE_ADD, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_beat(bfet_pkg::MODE_ADD, 32'd0, 24'd0);
        send_beat(bfet_pkg::MODE_ADD, 32'd5, 24'd10);
        send_beat(bfet_pkg::MODE_ADD, 32'd6, 24'd10);
        send_beat(bfet_pkg::MODE_FIND, 32'd0, 24'd7);
        send_beat(bfet_pkg::MODE_FIND, 32'd0, 24'hFF_FFFF);
        send_beat(bfet_pkg::MODE_DEL, 32'd5, 24'd10);
        send_beat(bfet_pkg::MODE_DEL, 32'd5, 24'd10);
        send_beat(bfet_pkg::MODE_DEL, 32'd0, 24'd1);
        send_beat(bfet_pkg::MODE_RSVD, 32'hA5A5_5A5A, 24'd3);
        hold_off = 400;
        for (int i = 0; i < DEPTH + 2; i++)
            send_beat(bfet_pkg::MODE_ADD, $urandom, rand_length());
        send_beat(bfet_pkg::MODE_FIND, 32'd0, 24'd0);
        for (int i = 0; i < DEPTH + 1; i++)
            send_beat(bfet_pkg::MODE_DEL, 32'd0, 24'd0);

        for (int n = 0; n < 1020; n++) begin
            if (n == 340) begin
                send_idle_pct = 88;
                recv_idle_pct = 29;
            end
            else if (n == 680) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_beat();
        end
        req_valid <= 1'b0;

        while (pending_count > 0)
            @(posedge clk);
        repeat (2 * DEPTH + 10) @(posedge clk);
        if (error_count == 0)
            $display("tb_best_fit_free_extent_table_core: PASS");
        else
            $display("tb_best_fit_free_extent_table_core: FAIL");
        $finish;
    end

endmodule

// File: files.f
src/bfet_pkg.sv
src/bfet_cell.sv
src/best_fit_free_extent_table_core.sv
src/bfet_checker.sv
test/bfet_checker.sv
test/tb_best_fit_free_extent_table_core.sv
